// ===== rtl/core/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg - triangle primitive assembler shared types
// Item layouts, mode codes and the command item that runs from the front
// part through the queue to the back part.
// ----------------------------------------------------------------------------
package tpa_pkg;

    // primitive_mode codes; code 3 is reserved and behaves as the list mode
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] vertex_id;
        logic [31:0] texcoord_index;
        logic        primitive_start;
        logic        object_start;
    } t_in_item;

    typedef struct packed {
        logic [31:0] corner0_vertex;
        logic [31:0] corner0_texcoord;
        logic [31:0] corner1_vertex;
        logic [31:0] corner1_texcoord;
        logic [31:0] corner2_vertex;
        logic [31:0] corner2_texcoord;
    } t_out_item;

    typedef struct packed {
        logic [31:0] texcoord;
        logic [31:0] vertex;
    } t_vertex;

    // how the vertex window moves
    typedef enum logic [1:0] {
        WIN_KEEP  = 2'd0,
        WIN_SHIFT = 2'd1,
        WIN_OLDER = 2'd2,
        WIN_NEWER = 2'd3
    } t_win_op;

    // which triangle, if any, the vertex closes
    typedef enum logic [2:0] {
        EMIT_NONE        = 3'd0,
        EMIT_LIST        = 3'd1,
        EMIT_STRIP_EVEN  = 3'd2,
        EMIT_STRIP_ODD   = 3'd3,
        EMIT_FAN         = 3'd4
    } t_emit;

    typedef struct packed {
        logic    load_anchor;
        t_win_op win;
        t_emit   emit;
        t_vertex cur;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ===== rtl/core/tpa_front.sv =====
// ----------------------------------------------------------------------------
// tpa_front - vertex classifier
// Tracks mode, position count and strip parity, and turns each vertex into
// a command for the back part.
// ----------------------------------------------------------------------------
module tpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_accept,
    input  tpa_pkg::t_in_item i_item,
    output tpa_pkg::t_cmd     o_cmd
);

    logic [1:0] r_mode;
    logic [1:0] r_cnt;
    logic       r_odd;
    logic [1:0] n_cnt;
    logic       n_odd;

    logic [1:0] cnt_sat;
    logic [1:0] cnt_eff;
    logic       par;
    logic       strip_fan;
    logic       prim;

    always_comb begin
        cnt_sat   = (r_cnt > 2'd2) ? 2'd2 : r_cnt;
        strip_fan = (r_mode == tpa_pkg::MODE_STRIP) || (r_mode == tpa_pkg::MODE_FAN);
        prim      = i_item.primitive_start | i_item.object_start;

        o_cmd.cur.vertex   = i_item.vertex_id;
        o_cmd.cur.texcoord = i_item.texcoord_index;
        o_cmd.load_anchor  = 1'b0;
        o_cmd.win          = tpa_pkg::WIN_KEEP;
        o_cmd.emit         = tpa_pkg::EMIT_NONE;
        cnt_eff            = cnt_sat;
        par                = 1'b0;
        n_cnt              = r_cnt;
        n_odd              = 1'b0;

        if (strip_fan) begin
            cnt_eff           = prim ? 2'd0 : cnt_sat;
            par               = prim ? 1'b0 : r_odd;
            o_cmd.load_anchor = (cnt_eff == 2'd0);
            o_cmd.win         = tpa_pkg::WIN_SHIFT;
            if (cnt_eff == 2'd2) begin
                if (r_mode == tpa_pkg::MODE_FAN) begin
                    o_cmd.emit = tpa_pkg::EMIT_FAN;
                end else if (par) begin
                    o_cmd.emit = tpa_pkg::EMIT_STRIP_ODD;
                end else begin
                    o_cmd.emit = tpa_pkg::EMIT_STRIP_EVEN;
                end
                n_cnt = 2'd2;
            end else begin
                n_cnt = cnt_eff + 2'd1;
            end
            n_odd = ~par;
        end else begin
            // list grouping restarts only on an object start
            cnt_eff           = i_item.object_start ? 2'd0 : cnt_sat;
            o_cmd.load_anchor = i_item.object_start;
            case (cnt_eff)
                2'd0: begin
                    o_cmd.win = tpa_pkg::WIN_OLDER;
                    n_cnt     = 2'd1;
                end
                2'd1: begin
                    o_cmd.win = tpa_pkg::WIN_NEWER;
                    n_cnt     = 2'd2;
                end
                default: begin
                    o_cmd.emit = tpa_pkg::EMIT_LIST;
                    n_cnt      = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tpa_pkg::MODE_LIST;
            r_cnt  <= 2'd0;
            r_odd  <= 1'b0;
        end else if (i_cfg_we) begin
            // new mode starts a fresh group; stored vertices stay
            r_mode <= i_cfg_data;
            r_cnt  <= 2'd0;
            r_odd  <= 1'b0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_odd <= n_odd;
        end
    end

endmodule

// ===== rtl/core/tpa_queue.sv =====
// ----------------------------------------------------------------------------
// tpa_queue - command queue
// Two-entry queue between the classifier and the triangle builder.
// ----------------------------------------------------------------------------
module tpa_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpa_pkg::t_queue_ctrl i_ctrl,
    input  tpa_pkg::t_cmd        i_cmd,
    output tpa_pkg::t_cmd        o_cmd,
    output tpa_pkg::t_queue_stat o_stat
);

    localparam int PTR_W = $clog2(tpa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tpa_pkg::QUEUE_DEPTH + 1);

    tpa_pkg::t_cmd    r_slot [tpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_cmd        = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(tpa_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/tpa_back.sv =====
// ----------------------------------------------------------------------------
// tpa_back - triangle builder
// Holds the vertex window, builds triangles from queued commands and
// keeps the result in the output register.
// ----------------------------------------------------------------------------
module tpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  tpa_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_item o_out_item
);

    tpa_pkg::t_vertex   r_anchor;
    tpa_pkg::t_vertex   r_older;
    tpa_pkg::t_vertex   r_newer;
    logic               r_out_valid;
    tpa_pkg::t_out_item r_out;

    tpa_pkg::t_vertex c0;
    tpa_pkg::t_vertex c1;
    logic             tri_ok;
    logic             can_load;

    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_cmd_take  = i_cmd_valid && can_load;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        c0     = r_older;
        c1     = r_newer;
        tri_ok = 1'b0;
        case (i_cmd.emit)
            tpa_pkg::EMIT_LIST: begin
                // degenerate list triangles are dropped
                tri_ok = (r_older.vertex != r_newer.vertex)
                      && (r_older.vertex != i_cmd.cur.vertex)
                      && (r_newer.vertex != i_cmd.cur.vertex);
            end
            tpa_pkg::EMIT_STRIP_EVEN: begin
                tri_ok = 1'b1;
            end
            tpa_pkg::EMIT_STRIP_ODD: begin
                c0     = r_newer;
                c1     = r_older;
                tri_ok = 1'b1;
            end
            tpa_pkg::EMIT_FAN: begin
                c0     = r_anchor;
                tri_ok = 1'b1;
            end
            default: begin
                tri_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            if (i_cmd.load_anchor) begin
                r_anchor <= i_cmd.cur;
            end
            case (i_cmd.win)
                tpa_pkg::WIN_SHIFT: begin
                    r_older <= r_newer;
                    r_newer <= i_cmd.cur;
                end
                tpa_pkg::WIN_OLDER: r_older <= i_cmd.cur;
                tpa_pkg::WIN_NEWER: r_newer <= i_cmd.cur;
                default: begin
                    r_older <= r_older;
                end
            endcase
        end
        if (o_cmd_take && tri_ok) begin
            r_out.corner0_vertex   <= c0.vertex;
            r_out.corner0_texcoord <= c0.texcoord;
            r_out.corner1_vertex   <= c1.vertex;
            r_out.corner1_texcoord <= c1.texcoord;
            r_out.corner2_vertex   <= i_cmd.cur.vertex;
            r_out.corner2_texcoord <= i_cmd.cur.texcoord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= o_cmd_take && tri_ok;
        end
    end

endmodule

// ===== rtl/core/triangle_primitive_assembler.sv =====
// ----------------------------------------------------------------------------
// triangle_primitive_assembler - triangle list / strip / fan assembly
// Input channel: one vertex item per accept (i_in_valid high, o_in_stall
// low). Output channel: one triangle item per accept (o_out_valid high,
// i_out_stall low); a vertex yields zero or one triangle.
// Config: i_cfg_we writes primitive_mode (list, strip, fan; code 3 acts as
// list) and restarts grouping. Write only while the block is idle.
// Throughput: one vertex per cycle, sustained while the output is taken.
// Path: the accept edge of the closing vertex writes its command into the
// queue; the builder loads the output register when it takes that command
// from the queue head, and o_out_valid rises with the loaded register.
// The front classifier updates position count and parity at accept and
// queues a command; the back builder owns the vertex window and output
// register. A stall on the output holds the output register; the two-entry
// queue then fills and o_in_stall rises. Vertices that close no triangle
// still pass the queue in order so the window stays in step.
// Reset (synchronous, i_rst_n low): list mode, empty queue, count and parity
// cleared, no output valid.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tpa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_item o_out_item
);

    tpa_pkg::t_cmd        front_cmd;
    tpa_pkg::t_cmd        head_cmd;
    tpa_pkg::t_queue_ctrl q_ctrl;
    tpa_pkg::t_queue_stat q_stat;
    logic                 in_accept;
    logic                 cmd_take;

    // stall only on a full queue; the output side never blocks directly
    assign o_in_stall  = q_stat.full;
    assign in_accept   = i_in_valid && !q_stat.full;
    assign q_ctrl.push = in_accept;
    assign q_ctrl.pop  = cmd_take;

    tpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_item     (i_in_item),
        .o_cmd      (front_cmd)
    );

    tpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_cmd   (front_cmd),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    tpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_stat.empty),
        .i_cmd       (head_cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
